@@ rtl/autorange_adc_averager_top_defines.svh @@
// Assertion macros used by the checker file.
`ifndef AUTORANGE_ADC_AVERAGER_TOP_DEFINES_SVH
`define AUTORANGE_ADC_AVERAGER_TOP_DEFINES_SVH

// Clocked assertion, quiet while reset is held.
`define ARAAVG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that also checks across reset.
`define ARAAVG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/araavg_pkg.sv @@
`timescale 1ns / 1ps

package araavg_pkg;

    // Field widths
    localparam int CONV_W     = 10;
    localparam int CAL_W      = 16;
    localparam int RANGE_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Default ring depth
    localparam int PKG_AVG_DEPTH = 8;

    // Largest conversion code
    localparam int CONV_MAX = 1023;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_RANGE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_SUPPLY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_LOW_REF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_MID_REF  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OVR_LEVEL    = 3'd5;

    // Register reset values
    localparam logic [RANGE_W-1:0] RST_MANUAL_RANGE = 2'd2;
    localparam logic [CAL_W-1:0]   RST_CAL_SUPPLY   = 16'd4690;
    localparam logic [CAL_W-1:0]   RST_CAL_LOW_REF  = 16'd1121;
    localparam logic [CAL_W-1:0]   RST_CAL_MID_REF  = 16'd2513;
    localparam int                 RST_OVR_LEVEL    = 1015;

    // Reference range codes
    localparam logic [RANGE_W-1:0] RNG_SUPPLY  = 2'd0;
    localparam logic [RANGE_W-1:0] RNG_LOW_REF = 2'd1;
    localparam logic [RANGE_W-1:0] RNG_MID_REF = 2'd2;

    // Sweep phase codes
    localparam logic [1:0] PH_LOW_REF = 2'd0;
    localparam logic [1:0] PH_MID_REF = 2'd1;
    localparam logic [1:0] PH_SUPPLY  = 2'd2;

    // Conversions dropped after a range change
    localparam logic [1:0] SETTLE_COUNT = 2'd2;

    // Millivolt scaling: product / 1023 by reciprocal multiply
    localparam int          MV_DIVISOR = 1023;
    localparam int          MV_PROD_W  = CONV_W + CAL_W;
    localparam int          MV_SHIFT   = MV_PROD_W + $clog2(MV_DIVISOR);
    localparam int          MV_RECIP_W = MV_PROD_W + 1;
    localparam logic [63:0] MV_RECIP   = (64'd1 << MV_SHIFT) / MV_DIVISOR + 64'd1;

    // Per-result side information that rides along the scaling pipeline
    typedef struct packed {
        logic [RANGE_W-1:0] ref_range;
        logic               discarded;
        logic               sweep_done;
    } t_meta;

endpackage

@@ rtl/araavg_ram.sv @@
`timescale 1ns / 1ps

module araavg_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/araavg_scale.sv @@
`timescale 1ns / 1ps

module araavg_scale import araavg_pkg::*; #(
    parameter int AVG_DEPTH = PKG_AVG_DEPTH,
    parameter int TOT_W     = $clog2(PKG_AVG_DEPTH * CONV_MAX + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // upstream side
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [TOT_W-1:0]  i_total,
    input  logic [CAL_W-1:0]  i_cal,
    input  t_meta             i_meta,
    // downstream side
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CONV_W-1:0] o_average,
    output logic [CAL_W-1:0]  o_millivolts,
    output t_meta             o_meta
);

    // total / AVG_DEPTH by round-up reciprocal, exact for any total < 2^TOT_W
    localparam int          AVG_SHIFT   = TOT_W + $clog2(AVG_DEPTH);
    localparam int          AVG_RECIP_W = TOT_W + 2;
    localparam logic [63:0] AVG_RECIP   = (64'd1 << AVG_SHIFT) / AVG_DEPTH + 64'd1;
    localparam int          AVG_PROD_W  = TOT_W + AVG_RECIP_W;
    localparam int          MV_FULL_W   = MV_PROD_W + MV_RECIP_W;

    // stage 1: running total and calibration
    logic                  r_s1_valid;
    logic [TOT_W-1:0]      r_s1_total;
    logic [CAL_W-1:0]      r_s1_cal;
    t_meta                 r_s1_meta;
    // stage 2: average
    logic                  r_s2_valid;
    logic [CONV_W-1:0]     r_s2_avg;
    logic [CAL_W-1:0]      r_s2_cal;
    t_meta                 r_s2_meta;
    // stage 3: average times calibration
    logic                  r_s3_valid;
    logic [CONV_W-1:0]     r_s3_avg;
    logic [MV_PROD_W-1:0]  r_s3_prod;
    t_meta                 r_s3_meta;
    // output register
    logic                  r_out_valid;
    logic [CONV_W-1:0]     r_out_avg;
    logic [CAL_W-1:0]      r_out_mv;
    t_meta                 r_out_meta;

    logic                  en_s1, en_s2, en_s3, en_out;
    logic [AVG_PROD_W-1:0] avg_prod;
    logic [MV_PROD_W-1:0]  cal_prod;
    logic [MV_FULL_W-1:0]  mv_prod;

    // A stage loads when it is empty or its contents move on
    assign en_out  = !r_out_valid || i_ready;
    assign en_s3   = !r_s3_valid  || en_out;
    assign en_s2   = !r_s2_valid  || en_s3;
    assign en_s1   = !r_s1_valid  || en_s2;
    assign o_ready = en_s1;

    // Arithmetic between the stages
    assign avg_prod = r_s1_total * AVG_RECIP[AVG_RECIP_W-1:0];
    assign cal_prod = r_s2_avg * r_s2_cal;
    assign mv_prod  = r_s3_prod * MV_RECIP[MV_RECIP_W-1:0];

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en_s1) begin
                r_s1_valid <= i_valid;
            end
            if (en_s2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (en_s3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (en_out) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (en_s1) begin
            r_s1_total <= i_total;
            r_s1_cal   <= i_cal;
            r_s1_meta  <= i_meta;
        end
        if (en_s2) begin
            r_s2_avg  <= avg_prod[AVG_SHIFT +: CONV_W];
            r_s2_cal  <= r_s1_cal;
            r_s2_meta <= r_s1_meta;
        end
        if (en_s3) begin
            r_s3_avg  <= r_s2_avg;
            r_s3_prod <= cal_prod;
            r_s3_meta <= r_s2_meta;
        end
        if (en_out) begin
            r_out_avg  <= r_s3_avg;
            r_out_mv   <= mv_prod[MV_SHIFT +: CAL_W];
            r_out_meta <= r_s3_meta;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_average    = r_out_avg;
    assign o_millivolts = r_out_mv;
    assign o_meta       = r_out_meta;

endmodule

@@ rtl/autorange_adc_averager_top.sv @@
`timescale 1ns / 1ps
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+----------------------------------
// in       | input     | i_in_valid / o_in_ready    | i_conversion
// out      | output    | o_out_valid / i_out_ready  | o_ref_range, o_discarded,
//          |           |                            | o_average, o_millivolts, o_sweep_done
// cfg      | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One conversion per clock while o_in_ready is high; o_out_valid comes from the scaling pipeline
// registers s1, s2, s3, out (average multiply, calibration multiply, divide-by-1023 multiply).
// Range, settling, sweep and running total update in the cycle a conversion is accepted.
// Reset is synchronous; the sample ring reads as zero until its first wrap (no clear pass).
// Output stalls back up stage by stage; o_in_ready drops only when all 4 stages are full.

module autorange_adc_averager_top import araavg_pkg::*; #(
    parameter int AVG_DEPTH = PKG_AVG_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // conversion input
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CONV_W-1:0]     i_conversion,
    // result output
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [RANGE_W-1:0]    o_ref_range,
    output logic                  o_discarded,
    output logic [CONV_W-1:0]     o_average,
    output logic [CAL_W-1:0]      o_millivolts,
    output logic                  o_sweep_done,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SLOT_W = $clog2(AVG_DEPTH);
    localparam int TOT_W  = $clog2(AVG_DEPTH * CONV_MAX + 1);
    localparam int TOT_X  = TOT_W + 1;
    localparam int OVR_W  = $clog2((CONV_MAX + 1) * AVG_DEPTH + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(AVG_DEPTH - 1);

    // configuration
    logic                 r_auto_mode;
    logic [RANGE_W-1:0]   r_manual_range;
    logic [CAL_W-1:0]     r_cal_supply;
    logic [CAL_W-1:0]     r_cal_low;
    logic [CAL_W-1:0]     r_cal_mid;
    logic [OVR_W-1:0]     r_ovr_total;   // (level + 1) * depth
    // running state
    logic [SLOT_W-1:0]    r_slot;
    logic                 r_wrapped;
    logic [TOT_W-1:0]     r_total;
    logic [RANGE_W-1:0]   r_applied;
    logic [1:0]           r_settle;
    logic [1:0]           r_phase;
    logic [SLOT_W-1:0]    r_samples;

    logic                 accept;
    logic                 cfg_wr;
    logic                 store;
    logic                 discard;
    logic                 over;
    logic                 done;
    logic                 slot_last;
    logic [RANGE_W-1:0]   want_pre, want_post;
    logic [RANGE_W-1:0]   applied_pre, n_applied;
    logic [1:0]           settle_pre, settle_mid, n_settle;
    logic [1:0]           n_phase;
    logic [SLOT_W-1:0]    n_samples;
    logic [SLOT_W-1:0]    n_slot;
    logic [CONV_W-1:0]    ring_rd;
    logic [CONV_W-1:0]    old_sample;
    logic [TOT_W-1:0]     total_upd, n_total;
    logic [CAL_W-1:0]     cal_sel;
    logic [OVR_W-1:0]     n_ovr_total;
    t_meta                meta;
    t_meta                out_meta;

    // Range the current mode and phase ask for
    function automatic logic [RANGE_W-1:0] wanted_range(
        input logic             auto_mode,
        input logic [1:0]       phase,
        input logic [RANGE_W-1:0] manual
    );
        logic [RANGE_W-1:0] rng;
        if (auto_mode) begin
            unique case (phase)
                PH_LOW_REF: rng = RNG_LOW_REF;
                PH_MID_REF: rng = RNG_MID_REF;
                default:    rng = RNG_SUPPLY;
            endcase
        end else begin
            rng = (manual > RNG_MID_REF) ? RNG_SUPPLY : manual;
        end
        return rng;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign accept      = i_in_valid && o_in_ready;

    // Follow the wanted range before the conversion is looked at
    always_comb begin
        want_pre = wanted_range(r_auto_mode, r_phase, r_manual_range);
        if (want_pre != r_applied) begin
            applied_pre = want_pre;
            settle_pre  = SETTLE_COUNT;
        end else begin
            applied_pre = r_applied;
            settle_pre  = r_settle;
        end
    end

    assign discard    = (settle_pre != 2'd0);
    assign settle_mid = discard ? settle_pre - 2'd1 : settle_pre;
    assign store      = accept && !discard;

    // Ring slot bookkeeping; the RAM is read one slot ahead
    assign slot_last  = (r_slot == LAST_SLOT);
    assign n_slot     = store ? (slot_last ? '0 : r_slot + 1'b1) : r_slot;
    assign old_sample = r_wrapped ? ring_rd : '0;

    // Running total
    assign total_upd = TOT_W'(TOT_X'(r_total) + TOT_X'(i_conversion) - TOT_X'(old_sample));
    assign n_total   = discard ? r_total : total_upd;

    // average > level  <=>  total >= (level + 1) * depth
    assign over = (OVR_W'(n_total) >= r_ovr_total);

    // Auto sweep progress
    always_comb begin
        n_phase   = r_phase;
        n_samples = r_samples;
        done      = 1'b0;
        if (!discard && r_auto_mode) begin
            if (r_samples == LAST_SLOT) begin
                n_samples = '0;
                if (r_phase < PH_SUPPLY && over) begin
                    n_phase = r_phase + 2'd1;
                end else begin
                    done    = 1'b1;
                    n_phase = PH_LOW_REF;
                end
            end else begin
                n_samples = r_samples + 1'b1;
            end
        end
    end

    // Follow the range again for the next conversion
    always_comb begin
        want_post = wanted_range(r_auto_mode, n_phase, r_manual_range);
        if (want_post != applied_pre) begin
            n_applied = want_post;
            n_settle  = SETTLE_COUNT;
        end else begin
            n_applied = applied_pre;
            n_settle  = settle_mid;
        end
    end

    // Calibration of the range this conversion was taken at
    always_comb begin
        unique case (applied_pre)
            RNG_LOW_REF: cal_sel = r_cal_low;
            RNG_MID_REF: cal_sel = r_cal_mid;
            default:     cal_sel = r_cal_supply;
        endcase
    end

    assign n_ovr_total = OVR_W'((OVR_W'(i_cfg_data[CONV_W-1:0]) + 1'b1) * AVG_DEPTH);

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_mode    <= 1'b0;
            r_manual_range <= RST_MANUAL_RANGE;
            r_cal_supply   <= RST_CAL_SUPPLY;
            r_cal_low      <= RST_CAL_LOW_REF;
            r_cal_mid      <= RST_CAL_MID_REF;
            r_ovr_total    <= OVR_W'((RST_OVR_LEVEL + 1) * AVG_DEPTH);
            r_slot         <= '0;
            r_wrapped      <= 1'b0;
            r_total        <= '0;
            r_applied      <= RNG_SUPPLY;
            r_settle       <= 2'd0;
            r_phase        <= PH_LOW_REF;
            r_samples      <= '0;
        end else begin
            if (accept) begin
                r_applied <= n_applied;
                r_settle  <= n_settle;
                r_phase   <= n_phase;
                r_samples <= n_samples;
                r_total   <= n_total;
                r_slot    <= n_slot;
                if (store && slot_last) begin
                    r_wrapped <= 1'b1;
                end
            end
            if (cfg_wr) begin
                unique case (i_cfg_index)
                    CFG_AUTO_MODE: begin
                        if (i_cfg_data[0] != r_auto_mode) begin
                            r_phase   <= PH_LOW_REF;
                            r_samples <= '0;
                        end
                        r_auto_mode <= i_cfg_data[0];
                    end
                    CFG_MANUAL_RANGE: r_manual_range <= i_cfg_data[RANGE_W-1:0];
                    CFG_CAL_SUPPLY:   r_cal_supply   <= i_cfg_data;
                    CFG_CAL_LOW_REF:  r_cal_low      <= i_cfg_data;
                    CFG_CAL_MID_REF:  r_cal_mid      <= i_cfg_data;
                    CFG_OVR_LEVEL:    r_ovr_total    <= n_ovr_total;
                    default: ;
                endcase
            end
        end
    end

    // Sample ring
    araavg_ram #(
        .WIDTH (CONV_W),
        .DEPTH (AVG_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (store),
        .i_wr_addr (r_slot),
        .i_wr_data (i_conversion),
        .i_rd_addr (n_slot),
        .o_rd_data (ring_rd)
    );

    assign meta.ref_range  = n_applied;
    assign meta.discarded  = discard;
    assign meta.sweep_done = done;

    // Average and millivolt pipeline with output register
    araavg_scale #(
        .AVG_DEPTH (AVG_DEPTH),
        .TOT_W     (TOT_W)
    ) u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (accept),
        .o_ready      (o_in_ready),
        .i_total      (n_total),
        .i_cal        (cal_sel),
        .i_meta       (meta),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_average    (o_average),
        .o_millivolts (o_millivolts),
        .o_meta       (out_meta)
    );

    assign o_ref_range  = out_meta.ref_range;
    assign o_discarded  = out_meta.discarded;
    assign o_sweep_done = out_meta.sweep_done;

endmodule

@@ rtl/araavg_chk.sv @@
`timescale 1ns / 1ps
`include "autorange_adc_averager_top_defines.svh"

module araavg_chk import araavg_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [RANGE_W-1:0] o_ref_range,
    input logic               o_discarded,
    input logic [CONV_W-1:0]  o_average,
    input logic [CAL_W-1:0]   o_millivolts,
    input logic               o_sweep_done
);

    // only ranges 0..2 are ever driven
    `ARAAVG_ASSERT(a_range_legal, o_out_valid |-> o_ref_range != 2'd3, "ref range code 3 driven")

    // a dropped conversion never closes a sweep
    `ARAAVG_ASSERT(a_discard_not_done, o_out_valid && o_discarded |-> !o_sweep_done, "sweep done on a discarded conversion")

    // a stalled result holds
    `ARAAVG_ASSERT(a_stall_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_average) && $stable(o_millivolts) && $stable(o_ref_range), "stalled result changed")

    // reset empties the pipeline
    `ARAAVG_ASSERT_ALWAYS(a_reset_empty, $past(!i_rst_n) |-> !o_out_valid, "result valid right after reset")

endmodule

bind autorange_adc_averager_top araavg_chk u_chk (.*);

@@ test/autorange_adc_averager_top_test.sv @@
`timescale 1ns / 1ps

module autorange_adc_averager_top_test;
    import araavg_pkg::*;

    localparam int DEPTH          = PKG_AVG_DEPTH;
    localparam int PIPE_SETTLE    = 8;
    localparam int TAIL_CYCLES    = 16;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 108;
    localparam int MAX_BURST      = 17;

    // Register indexes past the last register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
    // Manual range code that aliases to the supply range
    localparam logic [RANGE_W-1:0] RNG_ALIAS_SUPPLY = 2'd3;

    typedef struct packed {
        logic [RANGE_W-1:0] ref_range;
        logic               discarded;
        logic [CONV_W-1:0]  average;
        logic [CAL_W-1:0]   millivolts;
        logic               sweep_done;
    } reading_t;

    // Tracks registers and averager state, predicts one reading per conversion
    class conversion_ledger;
        logic               auto_on;
        logic [RANGE_W-1:0] manual_sel;
        logic [CAL_W-1:0]   cal_supply;
        logic [CAL_W-1:0]   cal_low;
        logic [CAL_W-1:0]   cal_mid;
        logic [CONV_W-1:0]  over_level;

        logic [CONV_W-1:0]  ring [DEPTH];
        logic [2:0]         slot;
        logic [12:0]        total;
        logic [RANGE_W-1:0] applied_rng;
        logic [1:0]         settle_cnt;
        logic [1:0]         sweep_ph;
        logic [3:0]         taken_cnt;

        reading_t    pending_readings[$];
        int unsigned failures;

        function new();
            auto_on     = 1'b0;
            manual_sel  = RST_MANUAL_RANGE;
            cal_supply  = RST_CAL_SUPPLY;
            cal_low     = RST_CAL_LOW_REF;
            cal_mid     = RST_CAL_MID_REF;
            over_level  = 10'(RST_OVR_LEVEL);
            foreach (ring[i]) ring[i] = '0;
            slot        = '0;
            total       = '0;
            applied_rng = RNG_SUPPLY;
            settle_cnt  = '0;
            sweep_ph    = PH_LOW_REF;
            taken_cnt   = '0;
            failures    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_AUTO_MODE: begin
                    // a mode change restarts the sweep
                    if (data[0] != auto_on) begin
                        sweep_ph  = PH_LOW_REF;
                        taken_cnt = '0;
                    end
                    auto_on = data[0];
                end
                CFG_MANUAL_RANGE: manual_sel = data[RANGE_W-1:0];
                CFG_CAL_SUPPLY:   cal_supply = data;
                CFG_CAL_LOW_REF:  cal_low    = data;
                CFG_CAL_MID_REF:  cal_mid    = data;
                CFG_OVR_LEVEL:    over_level = data[CONV_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [RANGE_W-1:0] wanted_range();
            logic [RANGE_W-1:0] r;
            if (auto_on) begin
                case (sweep_ph)
                    PH_LOW_REF: r = RNG_LOW_REF;
                    PH_MID_REF: r = RNG_MID_REF;
                    default:    r = RNG_SUPPLY;
                endcase
            end else begin
                r = (manual_sel == RNG_ALIAS_SUPPLY) ? RNG_SUPPLY : manual_sel;
            end
            return r;
        endfunction

        function logic [CAL_W-1:0] cal_for(logic [RANGE_W-1:0] r);
            logic [CAL_W-1:0] c;
            case (r)
                RNG_LOW_REF: c = cal_low;
                RNG_MID_REF: c = cal_mid;
                default:     c = cal_supply;
            endcase
            return c;
        endfunction

        // Range change starts the two-conversion settling window
        function void track_range();
            logic [RANGE_W-1:0] w;
            w = wanted_range();
            if (w != applied_rng) begin
                applied_rng = w;
                settle_cnt  = SETTLE_COUNT;
            end
        endfunction

        function void log_conversion(logic [CONV_W-1:0] conv);
            reading_t           r;
            logic [RANGE_W-1:0] taken_at;
            logic [25:0]        scaled;
            r = '0;
            track_range();
            taken_at = applied_rng;

            if (settle_cnt != 0) begin
                settle_cnt  = settle_cnt - 1'b1;
                r.discarded = 1'b1;
            end else begin
                total      = total - ring[slot] + conv;
                ring[slot] = conv;
                slot       = (slot == DEPTH - 1) ? 3'd0 : slot + 3'd1;
            end

            r.average    = CONV_W'(total / DEPTH);
            scaled       = r.average * cal_for(taken_at);
            r.millivolts = CAL_W'(scaled / MV_DIVISOR);

            // sweep bookkeeping on stored samples only
            if (!r.discarded && auto_on) begin
                taken_cnt = taken_cnt + 1'b1;
                if (taken_cnt >= DEPTH) begin
                    taken_cnt = '0;
                    if (sweep_ph == PH_LOW_REF && r.average > over_level) begin
                        sweep_ph = PH_MID_REF;
                    end else if (sweep_ph == PH_MID_REF && r.average > over_level) begin
                        sweep_ph = PH_SUPPLY;
                    end else begin
                        r.sweep_done = 1'b1;
                        sweep_ph     = PH_LOW_REF;
                    end
                end
            end

            track_range();
            r.ref_range = applied_rng;
            pending_readings.push_back(r);
        endfunction

        function void compare_result(reading_t got);
            reading_t exp;
            if (pending_readings.size() == 0) begin
                $error("result with nothing outstanding: average %0d, millivolts %0d",
                       got.average, got.millivolts);
                failures++;
                return;
            end
            exp = pending_readings.pop_front();
            if (got.ref_range != exp.ref_range) begin
                $error("ref_range: expected %0d, got %0d", exp.ref_range, got.ref_range);
                failures++;
            end
            if (got.discarded != exp.discarded) begin
                $error("discarded: expected %0d, got %0d", exp.discarded, got.discarded);
                failures++;
            end
            if (got.average != exp.average) begin
                $error("average: expected %0d, got %0d", exp.average, got.average);
                failures++;
            end
            if (got.millivolts != exp.millivolts) begin
                $error("millivolts: expected %0d, got %0d", exp.millivolts, got.millivolts);
                failures++;
            end
            if (got.sweep_done != exp.sweep_done) begin
                $error("sweep_done: expected %0d, got %0d", exp.sweep_done, got.sweep_done);
                failures++;
            end
        endfunction

        function int outstanding();
            return pending_readings.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [CONV_W-1:0]     i_conversion;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [RANGE_W-1:0]    o_ref_range;
    logic                  o_discarded;
    logic [CONV_W-1:0]     o_average;
    logic [CAL_W-1:0]      o_millivolts;
    logic                  o_sweep_done;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    conversion_ledger ledger;
    int               feed_idle_pct;
    int               stall_pct;
    int               stall_left;
    int               quiet_cycles;
    int               sample_level;

    autorange_adc_averager_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_conversion (i_conversion),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_ref_range  (o_ref_range),
        .o_discarded  (o_discarded),
        .o_average    (o_average),
        .o_millivolts (o_millivolts),
        .o_sweep_done (o_sweep_done),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // 100 MHz clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Transaction monitor: register writes, then conversions, then results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) ledger.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) ledger.log_conversion(i_conversion);
            if (o_out_valid && i_out_ready) begin
                ledger.compare_result({o_ref_range, o_discarded, o_average,
                                       o_millivolts, o_sweep_done});
            end
        end
    end

    // Result-side backpressure in random bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left  <= $urandom_range(1, MAX_BURST) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one conversion, maybe after an idle burst, and wait for acceptance
    task automatic feed(input logic [CONV_W-1:0] conv);
        if (feed_idle_pct != 0 && $urandom_range(0, 99) < feed_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, MAX_BURST)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_conversion <= conv;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // One register write; the caller drops valid after a batch
    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Hold off input until every predicted reading has come back
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (ledger.outstanding() != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [CAL_W-1:0] pick_cal();
        logic [CAL_W-1:0] c;
        case ($urandom_range(0, 5))
            0:       c = '0;
            1:       c = '1;
            default: c = CAL_W'($urandom);
        endcase
        return c;
    endfunction

    // Slowly wandering level with small noise and occasional random samples, so averages sit near the threshold
    function automatic logic [CONV_W-1:0] pick_conversion(input logic [CONV_W-1:0] threshold);
        int v;
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 4))
                0:       sample_level = 0;
                1:       sample_level = CONV_MAX;
                2, 3:    sample_level = threshold;
                default: sample_level = $urandom_range(0, CONV_MAX);
            endcase
        end
        if ($urandom_range(0, 4) == 0) return CONV_W'($urandom_range(0, CONV_MAX));
        v = sample_level + int'($urandom_range(0, 8)) - 4;
        if (v < 0) v = 0;
        if (v > CONV_MAX) v = CONV_MAX;
        return CONV_W'(v);
    endfunction

    initial begin
        logic [CONV_W-1:0]     opening [12];
        logic [CFG_DATA_W-1:0] mode_w;
        logic [CFG_DATA_W-1:0] manual_w;
        logic [CFG_DATA_W-1:0] sup_w;
        logic [CFG_DATA_W-1:0] low_w;
        logic [CFG_DATA_W-1:0] mid_w;
        logic [CFG_DATA_W-1:0] ovr_w;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_conversion  = '0;
        i_out_ready   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        feed_idle_pct = 0;
        stall_pct     = 0;
        stall_left    = 0;
        quiet_cycles  = 0;
        sample_level  = CONV_MAX / 2;
        ledger        = new();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: manual mid range vs. applied supply range -> settling first
        feed_idle_pct = 25;
        stall_pct    <= 25;
        opening = '{10'd0, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
                    10'd1023, 10'd1023, 10'd1023, 10'h155, 10'h2AA, 10'd0};
        foreach (opening[i]) feed(opening[i]);
        wait_for_drain();

        // Manual range 3 aliases to supply; spare indexes must not disturb anything
        cfg_put(CFG_MANUAL_RANGE, {14'h3FFF, RNG_ALIAS_SUPPLY});
        cfg_put(CFG_CAL_SUPPLY, 16'hFFFF);
        cfg_put(CFG_SPARE_6, 16'hFFFF);
        cfg_put(CFG_SPARE_7, 16'h0000);
        i_cfg_valid <= 1'b0;
        feed(10'd1023);
        feed(10'd1023);
        feed(10'd1023);
        feed(10'd1023);
        feed(10'd0);
        feed(10'd1023);

        // Random phases, each with its own register setting
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_for_drain();
            mode_w   = CFG_DATA_W'($urandom);
            manual_w = CFG_DATA_W'($urandom);
            sup_w    = pick_cal();
            low_w    = pick_cal();
            mid_w    = pick_cal();
            ovr_w    = CFG_DATA_W'($urandom);
            case ($urandom_range(0, 3))
                0:       ovr_w[CONV_W-1:0] = '0;
                1:       ovr_w[CONV_W-1:0] = CONV_W'(CONV_MAX);
                default: ;
            endcase
            if (ph == 0) begin
                // auto sweeps that can never widen, full-scale calibration
                mode_w[0]          = 1'b1;
                sup_w              = '1;
                low_w              = '1;
                mid_w              = '1;
                ovr_w[CONV_W-1:0]  = CONV_W'(CONV_MAX);
            end else if (ph == 1) begin
                // auto sweeps that widen on any nonzero average, zero calibration
                mode_w[0]          = 1'b1;
                sup_w              = '0;
                low_w              = '0;
                mid_w              = '0;
                ovr_w[CONV_W-1:0]  = '0;
            end else if (ph == 2) begin
                mode_w[0]          = 1'b0;
                manual_w[1:0]      = RNG_ALIAS_SUPPLY;
            end else if (ph % 3 != 0) begin
                mode_w[0]          = 1'b1;
            end

            cfg_put(CFG_AUTO_MODE, mode_w);
            cfg_put(CFG_MANUAL_RANGE, manual_w);
            cfg_put(CFG_CAL_SUPPLY, sup_w);
            cfg_put(CFG_CAL_LOW_REF, low_w);
            cfg_put(CFG_CAL_MID_REF, mid_w);
            cfg_put(CFG_OVR_LEVEL, ovr_w);
            if ($urandom_range(0, 2) == 0) begin
                cfg_put($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7,
                        CFG_DATA_W'($urandom));
            end
            i_cfg_valid <= 1'b0;

            // idling mix per phase; the final phase runs flat out
            if (ph == RANDOM_PHASES - 1) begin
                feed_idle_pct = 0;
                stall_pct    <= 0;
            end else begin
                case ($urandom_range(0, 2))
                    0:       feed_idle_pct = 0;
                    1:       feed_idle_pct = 15;
                    default: feed_idle_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0:       stall_pct <= 0;
                    1:       stall_pct <= 15;
                    default: stall_pct <= 40;
                endcase
            end

            sample_level = ovr_w[CONV_W-1:0];
            for (int n = 0; n < PHASE_ITEMS; n++) feed(pick_conversion(ovr_w[CONV_W-1:0]));
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (ledger.failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
